// ===== hw/rtl/p2a_pkg.sv =====
// ----------------------------------------------------------------------------
// p2a_pkg: shared types and constants of the planar to ARGB converter
// Field widths, mode and register codes, and the structs between modules.
// ----------------------------------------------------------------------------
package p2a_pkg;

  // Field widths
  localparam int PIXELS_PER_GROUP = 8;
  localparam int PIX_IDX_W        = 3;
  localparam int PIX_CNT_W        = 4;
  localparam int PEN_W            = 8;
  localparam int PLANES_W         = 64;
  localparam int COLOR_W          = 24;
  localparam int ALPHA_W          = 8;
  localparam int ARGB_W           = 32;
  localparam int DEPTH_W          = 4;
  localparam int COUNT_W          = 9;
  localparam int MODE_W           = 3;

  // Opcodes of an input item
  localparam logic OPCODE_LOAD   = 1'b0;
  localparam logic OPCODE_PIXELS = 1'b1;

  // Masking modes
  localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MASK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRANSP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LASSO  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALPHA  = 3'd4;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_DEPTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASKING_MODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_PRESENT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT_PEN = 3'd4;

  // Alpha values
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [DEPTH_W-1:0] plane_depth;
    logic [COUNT_W-1:0] color_count;
    logic [MODE_W-1:0]  masking_mode;
    logic               mask_present;
    logic [PEN_W-1:0]   transparent_pen;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    plane_depth:     4'd8,
    color_count:     9'd256,
    masking_mode:    MODE_NONE,
    mask_present:    1'b0,
    transparent_pen: 8'd0
  };

  // Palette write request
  typedef struct packed {
    logic               we;
    logic [PEN_W-1:0]   addr;
    logic [COLOR_W-1:0] data;
  } ram_wr_t;

  // Palette read request
  typedef struct packed {
    logic             en;
    logic [PEN_W-1:0] addr;
  } ram_rd_t;

  // Pixel in flight beside its palette read
  typedef struct packed {
    logic valid;
    logic last;
    logic black;
    logic opaque;
  } meta_t;

endpackage

// ===== hw/rtl/p2a_in_if.sv =====
// ----------------------------------------------------------------------------
// p2a_in_if: input item channel
// Valid/ready channel carrying palette loads and eight-pixel groups.
// ----------------------------------------------------------------------------
interface p2a_in_if;
  import p2a_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [PEN_W-1:0]       palette_index;
  logic [COLOR_W-1:0]     palette_color;
  logic [PLANES_W-1:0]    plane_bits;
  logic [PIXELS_PER_GROUP-1:0] mask_bits;
  logic [PIX_CNT_W-1:0]   valid_pixels;

  modport source (
    output valid, opcode, palette_index, palette_color, plane_bits, mask_bits,
           valid_pixels,
    input  ready
  );

  modport sink (
    input  valid, opcode, palette_index, palette_color, plane_bits, mask_bits,
           valid_pixels,
    output ready
  );
endinterface

// ===== hw/rtl/p2a_out_if.sv =====
// ----------------------------------------------------------------------------
// p2a_out_if: result channel
// Valid/ready channel carrying one ARGB pixel per transfer.
// ----------------------------------------------------------------------------
interface p2a_out_if;
  import p2a_pkg::*;

  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] pixel_argb;
  logic              last_pixel;

  modport source (
    output valid, pixel_argb, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_argb, last_pixel,
    output ready
  );
endinterface

// ===== hw/rtl/p2a_ram.sv =====
// ----------------------------------------------------------------------------
// p2a_ram: generic single-clock RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module p2a_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/p2a_group_seq.sv =====
// ----------------------------------------------------------------------------
// p2a_group_seq: item intake and pixel sequencer
// Writes palette loads, steps through a group one pixel a cycle while not stalled,
// builds the pen, issues the palette read and carries the pixel's flags beside it.
// ----------------------------------------------------------------------------
module p2a_group_seq #(
  parameter int MAX_PLANES      = 8,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  p2a_pkg::cfg_t    cfg,
  p2a_in_if.sink           in_ch,
  input  logic             advance,
  output p2a_pkg::ram_wr_t wr,
  output p2a_pkg::ram_rd_t rd,
  output p2a_pkg::meta_t   meta
);
  import p2a_pkg::*;

  localparam logic [COUNT_W-1:0] ENTRIES_LIM = COUNT_W'(PALETTE_ENTRIES);
  localparam logic [DEPTH_W-1:0] PLANES_LIM  = DEPTH_W'(MAX_PLANES);
  localparam logic [PIX_CNT_W-1:0] GROUP_LIM = PIX_CNT_W'(PIXELS_PER_GROUP);
  localparam logic [PIX_IDX_W-1:0] PIX_MSB   = PIX_IDX_W'(PIXELS_PER_GROUP - 1);

  // Group under conversion
  logic                        busy_r, busy_nxt;
  logic [PIX_IDX_W-1:0]        x_r, x_nxt;
  logic [PIX_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PLANES_W-1:0]         planes_r;
  logic [PIXELS_PER_GROUP-1:0] mask_r;
  meta_t                       meta_r, meta_nxt;

  logic                        accept, accept_load, accept_group;
  logic                        r_free, issue, last_now;
  logic [PIX_CNT_W-1:0]        in_cnt;
  logic [DEPTH_W-1:0]          depth_eff;
  logic [PIX_IDX_W-1:0]        bit_idx;
  logic [MAX_PLANES-1:0]       pen;
  logic [PEN_W-1:0]            pen8;
  logic [PIXELS_PER_GROUP-1:0] plane_byte;
  logic                        use_mask, use_pen, black, opaque;

  // Handshake
  assign r_free   = !meta_r.valid || advance;
  assign issue    = busy_r && r_free;
  assign last_now = ({1'b0, x_r} + PIX_CNT_W'(1)) == cnt_r;

  assign in_ch.ready  = !busy_r || (issue && last_now);
  assign accept       = in_ch.valid && in_ch.ready;
  assign accept_load  = accept && (in_ch.opcode == OPCODE_LOAD);
  assign accept_group = accept && (in_ch.opcode == OPCODE_PIXELS);
  assign in_cnt       = (in_ch.valid_pixels > GROUP_LIM) ? GROUP_LIM : in_ch.valid_pixels;

  // Palette write straight from the transfer
  always_comb begin
    wr.we   = accept_load && ({1'b0, in_ch.palette_index} < ENTRIES_LIM);
    wr.addr = in_ch.palette_index;
    wr.data = in_ch.palette_color;
  end

  // Build the pen of the current pixel from the enabled planes
  assign depth_eff = (cfg.plane_depth > PLANES_LIM) ? PLANES_LIM : cfg.plane_depth;
  assign bit_idx   = PIX_MSB - x_r;

  always_comb begin
    for (int d = 0; d < MAX_PLANES; d++) begin
      plane_byte = planes_r[d*PIXELS_PER_GROUP +: PIXELS_PER_GROUP];
      pen[d]     = (DEPTH_W'(d) < depth_eff) && plane_byte[bit_idx];
    end
  end

  assign pen8 = PEN_W'(pen);

  // Decode the masking mode
  always_comb begin
    unique case (cfg.masking_mode) inside
      MODE_MASK, MODE_ALPHA: begin
        use_mask = cfg.mask_present;
        use_pen  = 1'b0;
      end
      MODE_TRANSP, MODE_LASSO: begin
        use_mask = cfg.mask_present;
        use_pen  = 1'b1;
      end
      default: begin
        use_mask = 1'b0;
        use_pen  = 1'b0;
      end
    endcase
  end

  // Black outside the color range, alpha from mask or transparent pen
  always_comb begin
    black  = !({1'b0, pen8} < cfg.color_count) || !({1'b0, pen8} < ENTRIES_LIM);
    opaque = 1'b1;
    if (use_mask) begin
      opaque = mask_r[bit_idx];
    end else if (use_pen && (pen8 == cfg.transparent_pen)) begin
      opaque = 1'b0;
    end
  end

  // Palette read request
  always_comb begin
    rd.en   = issue;
    rd.addr = pen8;
  end

  // Advance the sequencer
  always_comb begin
    busy_nxt = busy_r;
    x_nxt    = x_r;
    cnt_nxt  = cnt_r;
    if (issue) begin
      x_nxt = x_r + PIX_IDX_W'(1);
      if (last_now) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept_group) begin
      busy_nxt = (in_cnt != '0);
      x_nxt    = '0;
      cnt_nxt  = in_cnt;
    end
  end

  // Pixel flags beside the read; hold while the output stage stalls
  always_comb begin
    meta_nxt = meta_r;
    if (issue) begin
      meta_nxt.valid  = 1'b1;
      meta_nxt.last   = last_now;
      meta_nxt.black  = black;
      meta_nxt.opaque = opaque;
    end else if (advance) begin
      meta_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      x_r    <= '0;
      cnt_r  <= '0;
      meta_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      x_r    <= x_nxt;
      cnt_r  <= cnt_nxt;
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_group) begin
      planes_r <= in_ch.plane_bits;
      mask_r   <= in_ch.mask_bits;
    end
  end

  assign meta = meta_r;

`ifndef SYNTH
  // A new item is taken during a group only as its last pixel issues
  a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && busy_r) |-> (issue && last_now))
    else $error("item taken in the middle of a group");

  // The pixel index stays inside the group
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, x_r} < cnt_r))
    else $error("pixel index past group count");

  // A stalled pixel keeps its flags until the output stage takes it
  a_meta_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (meta_r.valid && !advance) |=> (meta_r.valid && $stable(meta_r)))
    else $error("stalled pixel flags changed");

  // No palette write while reads of an earlier group are still to come
  a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr.we |-> (!busy_r || last_now))
    else $error("palette write ahead of pending reads");
`endif

endmodule

// ===== hw/rtl/p2a_argb_out.sv =====
// ----------------------------------------------------------------------------
// p2a_argb_out: pixel assembly and output register
// Joins palette data with the pixel flags and holds the ARGB result until
// the sink takes it.
// ----------------------------------------------------------------------------
module p2a_argb_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  p2a_pkg::meta_t              meta,
  input  logic [p2a_pkg::COLOR_W-1:0] rd_data,
  p2a_out_if.source                   out_ch,
  output logic                        advance
);
  import p2a_pkg::*;

  logic              o_valid_r, o_valid_nxt;
  logic [ARGB_W-1:0] o_argb_r;
  logic              o_last_r;
  logic [ARGB_W-1:0] argb;

  // Take the pixel when the register is empty or drains this cycle
  assign advance = meta.valid && (!o_valid_r || out_ch.ready);

  // Assemble alpha and color
  assign argb = {(meta.opaque ? ALPHA_OPAQUE : ALPHA_CLEAR),
                 (meta.black ? COLOR_W'(0) : rd_data)};

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (advance) begin
      o_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_argb_r <= argb;
      o_last_r <= meta.last;
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.pixel_argb = o_argb_r;
  assign out_ch.last_pixel = o_last_r;

endmodule

// ===== hw/rtl/planar_to_argb_palette_converter.sv =====
// Throughput: one pixel per cycle unless the output sink stalls, set by the single
//   palette read port; a palette load is written straight from its transfer.
// The next group is taken in the cycle its predecessor issues its last read.
// Reset: configuration returns to defaults and the pipeline empties; the palette
//   RAM is not cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
// planar_to_argb_palette_converter: bitplane to ARGB converter top level
// Configuration registers, palette RAM, pixel sequencer and output stage.
// ----------------------------------------------------------------------------
module planar_to_argb_palette_converter #(
  parameter int MAX_PLANES      = 8,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  p2a_in_if.sink                          in_ch,
  p2a_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [p2a_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [p2a_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import p2a_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  cfg_t               cfg_r, cfg_nxt;
  ram_wr_t            wr;
  ram_rd_t            rd;
  meta_t              meta;
  logic               advance;
  logic [COLOR_W-1:0] rd_data;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLANE_DEPTH:     cfg_nxt.plane_depth     = cfg_wdata[DEPTH_W-1:0];
        CFG_COLOR_COUNT:     cfg_nxt.color_count     = cfg_wdata[COUNT_W-1:0];
        CFG_MASKING_MODE:    cfg_nxt.masking_mode    = cfg_wdata[MODE_W-1:0];
        CFG_MASK_PRESENT:    cfg_nxt.mask_present    = cfg_wdata[0];
        CFG_TRANSPARENT_PEN: cfg_nxt.transparent_pen = cfg_wdata[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Intake and pixel sequencing
  p2a_group_seq #(
    .MAX_PLANES      (MAX_PLANES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .advance (advance),
    .wr      (wr),
    .rd      (rd),
    .meta    (meta)
  );

  // Palette storage
  p2a_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr[AW-1:0]),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr[AW-1:0]),
    .rdata (rd_data)
  );

  // Pixel assembly and output register
  p2a_argb_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .meta    (meta),
    .rd_data (rd_data),
    .out_ch  (out_ch),
    .advance (advance)
  );

endmodule
